### rtl/svd_pkg.sv
// ----------------------------------------------------------------------------
// Signed varint decoder package
// Shared types, constants and status codes for the sign-magnitude varint
// decoder.
// ----------------------------------------------------------------------------
package svd_pkg;

   // Width of the decoded value before it is given as a 32-bit result
   localparam int VALUE_WIDTH = 32;
   // Magnitude bits kept, so the negation always fits in VALUE_WIDTH bits
   localparam int MAG_WIDTH   = VALUE_WIDTH - 1;
   // Group position register and its saturation value
   localparam int POS_WIDTH   = 6;
   localparam logic [POS_WIDTH-1:0] POS_FIRST = '0;
   localparam logic [POS_WIDTH-1:0] POS_MAX   = '1;
   // Bits contributed by the first byte and by each later byte
   localparam int FIRST_BITS  = 6;
   localparam int GROUP_BITS  = 7;
   // Span of a group shifted to the largest position
   localparam int SHIFT_WIDTH = (1 << POS_WIDTH) - 1 + GROUP_BITS;

   // Byte layout
   localparam int BIT_MORE = 7;
   localparam int BIT_SIGN = 6;

   // Result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic signed [31:0] decoded_value;
      logic [1:0]         status;
   } rsp_type;

   // Decoder state carried from byte to byte
   typedef struct packed {
      logic [MAG_WIDTH-1:0] magnitude;
      logic [POS_WIDTH-1:0] position;
      logic                 negative;
      logic                 overflow;
   } svd_state_type;

endpackage

### rtl/svd_step.sv
// ----------------------------------------------------------------------------
// Signed varint decoder step
// Folds one message byte into the decoder state and forms the result that a
// terminating byte or a buffer end produces.
// ----------------------------------------------------------------------------
module svd_step (
   input  svd_pkg::svd_state_type state_cur,
   input  svd_pkg::req_type       req_item,
   output svd_pkg::svd_state_type state_next,
   output logic                   emit,
   output svd_pkg::rsp_type       rsp_item
);
   import svd_pkg::*;

   logic                          first;
   logic [GROUP_BITS-1:0]         group;
   logic [SHIFT_WIDTH-1:0]        shifted;
   logic [MAG_WIDTH-1:0]          mag_acc;
   logic                          ovf_acc;
   logic                          neg_acc;
   logic [POS_WIDTH:0]            pos_sum;
   logic [POS_WIDTH-1:0]          pos_acc;
   logic                          more;
   logic signed [VALUE_WIDTH-1:0] value;

   // Pick the magnitude group and sign of this byte
   always_comb begin
      first   = (state_cur.position == POS_FIRST);
      group   = first ? GROUP_BITS'(req_item.byte_in[FIRST_BITS-1:0])
                      : req_item.byte_in[GROUP_BITS-1:0];
      neg_acc = first ? req_item.byte_in[BIT_SIGN] : state_cur.negative;
   end

   // Place the group; any set bit at or above the kept width is overflow
   always_comb begin
      shifted = SHIFT_WIDTH'(group) << state_cur.position;
      mag_acc = state_cur.magnitude | shifted[MAG_WIDTH-1:0];
      ovf_acc = state_cur.overflow | (|shifted[SHIFT_WIDTH-1:MAG_WIDTH]);
   end

   // Advance the group position, saturating at the top
   always_comb begin
      pos_sum = first ? (POS_WIDTH+1)'(FIRST_BITS)
                      : {1'b0, state_cur.position} + (POS_WIDTH+1)'(GROUP_BITS);
      pos_acc = pos_sum[POS_WIDTH] ? POS_MAX : pos_sum[POS_WIDTH-1:0];
   end

   // Form the result and clear the state when the number ends
   always_comb begin
      more  = req_item.byte_in[BIT_MORE];
      emit  = !more || req_item.end_of_buffer;
      value = neg_acc ? -$signed(VALUE_WIDTH'(mag_acc)) : $signed(VALUE_WIDTH'(mag_acc));

      priority if (more) begin
         rsp_item.decoded_value = '0;
         rsp_item.status        = STATUS_TRUNCATED;
      end else if (ovf_acc) begin
         rsp_item.decoded_value = '0;
         rsp_item.status        = STATUS_OVERFLOW;
      end else begin
         rsp_item.decoded_value = 32'(value);
         rsp_item.status        = STATUS_OK;
      end

      if (emit) begin
         state_next = '0;
      end else begin
         state_next.magnitude = mag_acc;
         state_next.position  = pos_acc;
         state_next.negative  = neg_acc;
         state_next.overflow  = ovf_acc;
      end
   end

endmodule

### rtl/signed_varint_decoder_unit.sv
// ----------------------------------------------------------------------------
// Signed varint decoder unit
// Decodes sign-magnitude variable-length integers from a stream of bytes.
// ----------------------------------------------------------------------------
// One byte is taken per clock. A byte with bit 7 clear ends the number and
// its result appears on the rsp channel in the cycle after the byte transfer;
// a continuation byte marked end_of_buffer gives a truncated status instead,
// and other continuation bytes give no result. The single result register
// sets the rate: while it is free or being taken, a new byte is accepted in
// every cycle, so a stalled rsp side holds the req side only once a result
// is waiting. The decoder state is cleared by reset and after every result.
module signed_varint_decoder_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  svd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output svd_pkg::rsp_type rsp_payload
);
   import svd_pkg::*;

   svd_state_type state_ff, state_in, state_step;
   rsp_type       result_ff, result_in, result_step;
   logic          valid_ff, valid_in;
   logic          emit;
   logic          req_xfer;

   svd_step u_step (
      .state_cur  (state_ff),
      .req_item   (req_payload),
      .state_next (state_step),
      .emit       (emit),
      .rsp_item   (result_step)
   );

   // Accept a byte whenever the result register is free or draining
   assign req_ready = !valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   // Advance state and load the result register on a transfer
   always_comb begin
      state_in  = state_ff;
      result_in = result_ff;
      valid_in  = valid_ff && !rsp_ready;
      if (req_xfer) begin
         state_in = state_step;
         if (emit) begin
            result_in = result_step;
            valid_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = result_ff;

endmodule

### rtl/svd_checker.sv
// ----------------------------------------------------------------------------
// Signed varint decoder checker
// Port-level properties of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module svd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input svd_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input svd_pkg::rsp_type rsp_payload
);
   import svd_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed or dropped");

   // Drive a zero value with any status other than ok
   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != STATUS_OK |-> rsp_payload.decoded_value == 0)
      else $error("nonzero value with error status");

   // Give a result after a terminating byte
   a_term_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_payload.byte_in[BIT_MORE] |=> rsp_valid)
      else $error("terminating byte gave no result");

   // Flag truncation for a continuation byte at buffer end
   a_truncated: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.byte_in[BIT_MORE] && req_payload.end_of_buffer
      |=> rsp_valid && rsp_payload.status == STATUS_TRUNCATED)
      else $error("missing truncated status");

   // Give no new result for a continuation byte inside the buffer
   a_no_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.byte_in[BIT_MORE] && !req_payload.end_of_buffer
      |=> rsp_valid == $past(rsp_valid && !rsp_ready))
      else $error("result from continuation byte");

endmodule

bind signed_varint_decoder_unit svd_checker u_svd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Signed varint decoder unit testbench
// Streams bytes into the decoder and checks every decoded value and status
// against a software decode of the same stream, under bursty input,
// patterned output stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

   import svd_pkg::*;

   localparam int REPORT_LIMIT = 10;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // Decode state of the software decoder
   logic [63:0] soft_mag = '0;
   int unsigned soft_pos = 0;
   logic        soft_neg = 1'b0;
   logic        soft_ovf = 1'b0;

   // Results owed by the block, oldest first
   rsp_type     pending_results[$];
   int          fail_count  = 0;
   int          bytes_sent  = 0;

   // Sender pacing
   int          tx_max_gap   = 0;
   int          tx_max_burst = 1;
   int          tx_burst_left = 0;

   // Receiver pacing
   int          rx_max_stall = 0;
   int          rx_max_run   = 1;
   int          rx_run_left  = 0;
   logic        rx_stalled   = 1'b0;
   int          rx_hold_req  = 0;
   int          rx_hold_left = 0;

   signed_varint_decoder_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // Merge one magnitude group at a bit position, flag bits past the width
   function automatic void merge_group(logic [63:0] group, int unsigned at);
      int unsigned lim  = VALUE_WIDTH - 1;
      logic [63:0] keep = (64'd1 << lim) - 64'd1;
      if (at >= lim) begin
         if (group != 0) soft_ovf = 1'b1;
         return;
      end
      if ((group >> (lim - at)) != 0) soft_ovf = 1'b1;
      soft_mag = (soft_mag | (group << at)) & keep;
   endfunction

   function automatic void clear_number();
      soft_mag = '0;
      soft_pos = 0;
      soft_neg = 1'b0;
      soft_ovf = 1'b0;
   endfunction

   // Advance the software decoder by one byte, queue any result it gives
   function automatic void decode_byte(req_type item);
      logic               more = item.byte_in[BIT_MORE];
      int unsigned        next;
      logic signed [63:0] wide;
      rsp_type            res;
      if (soft_pos == 0) begin
         soft_neg = item.byte_in[BIT_SIGN];
         merge_group({58'd0, item.byte_in[FIRST_BITS-1:0]}, 0);
         next = FIRST_BITS;
      end else begin
         merge_group({57'd0, item.byte_in[GROUP_BITS-1:0]}, soft_pos);
         next = soft_pos + GROUP_BITS;
      end
      soft_pos = (next > POS_MAX) ? POS_MAX : next;

      if (more && !item.end_of_buffer) return;
      if (more) begin
         res.decoded_value = '0;
         res.status        = STATUS_TRUNCATED;
      end else if (soft_ovf) begin
         res.decoded_value = '0;
         res.status        = STATUS_OVERFLOW;
      end else begin
         wide = soft_neg ? -soft_mag : soft_mag;
         // Sign-extend from the value width
         wide = (wide <<< (64 - VALUE_WIDTH)) >>> (64 - VALUE_WIDTH);
         res.decoded_value = wide[31:0];
         res.status        = STATUS_OK;
      end
      pending_results.push_back(res);
      clear_number();
   endfunction

   // Insert a random gap between bursts of transfers
   task automatic pace_sender();
      int gap;
      if (tx_max_gap == 0) return;
      if (tx_burst_left == 0) begin
         gap = $urandom_range(0, tx_max_gap);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         tx_burst_left = $urandom_range(1, tx_max_burst);
      end
      tx_burst_left--;
   endtask

   // Offer one byte and hold it until the transfer
   task automatic offer_byte(logic [7:0] value, logic eob);
      req_type item;
      item.byte_in       = value;
      item.end_of_buffer = eob;
      pace_sender();
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_byte(item);
      bytes_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Receiver: long hold-off on request, else a run-length stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rx_hold_req != 0) begin
         rx_hold_left = rx_hold_req;
         rx_hold_req  = 0;
         rsp_ready <= 1'b0;
      end else if (rx_hold_left != 0) begin
         rx_hold_left--;
         rsp_ready <= 1'b0;
      end else if (rx_max_stall == 0) begin
         rsp_ready <= 1'b1;
      end else begin
         if (rx_run_left == 0) begin
            rx_stalled  = !rx_stalled;
            rx_run_left = rx_stalled ? $urandom_range(1, rx_max_stall)
                                     : $urandom_range(1, rx_max_run);
         end
         rx_run_left--;
         rsp_ready <= !rx_stalled;
      end
   end

   // Compare each result transfer with the oldest owed result
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            if (fail_count < REPORT_LIMIT)
               $display("unexpected result: value %0d status %0d",
                        rsp_payload.decoded_value, rsp_payload.status);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.decoded_value !== want.decoded_value ||
                rsp_payload.status !== want.status) begin
               if (fail_count < REPORT_LIMIT)
                  $display("mismatch after %0d bytes: expected %0d/%0d, got %0d/%0d",
                           bytes_sent, want.decoded_value, want.status,
                           rsp_payload.decoded_value, rsp_payload.status);
               fail_count++;
            end
         end
      end
   end

   // Field extremes and each special case of the byte format
   task automatic test_directed();
      tx_max_gap   = 0;
      rx_max_stall = 0;
      offer_byte(8'h00, 1'b0);              // zero
      offer_byte(8'h3F, 1'b1);              // largest one-byte value at buffer end
      offer_byte(8'h40, 1'b0);              // negative zero
      offer_byte(8'h7F, 1'b0);              // most negative one-byte value
      // Largest magnitude that fits
      offer_byte(8'hBF, 1'b0);
      offer_byte(8'hFF, 1'b0);
      offer_byte(8'hFF, 1'b0);
      offer_byte(8'hFF, 1'b0);
      offer_byte(8'h0F, 1'b0);
      // One magnitude bit past the width, negative
      offer_byte(8'hFF, 1'b0);
      offer_byte(8'hFF, 1'b0);
      offer_byte(8'hFF, 1'b0);
      offer_byte(8'hFF, 1'b0);
      offer_byte(8'h1F, 1'b0);
      // Continuation at buffer end
      offer_byte(8'h80, 1'b1);
      // Zero groups beyond the width are harmless
      offer_byte(8'h81, 1'b0);
      offer_byte(8'h80, 1'b0);
      offer_byte(8'h80, 1'b0);
      offer_byte(8'h80, 1'b0);
      offer_byte(8'h80, 1'b0);
      offer_byte(8'h00, 1'b0);
      // Truncation wins over a pending overflow
      offer_byte(8'hC0, 1'b0);
      offer_byte(8'h80, 1'b0);
      offer_byte(8'h80, 1'b0);
      offer_byte(8'h80, 1'b0);
      offer_byte(8'h90, 1'b1);
      wait_for_results();
   endtask

   // Mostly well-formed numbers with random content, some noise and cut-offs
   task automatic test_random_stream(int n_bytes);
      int          start = bytes_sent;
      int          pick;
      int          len;
      logic [7:0]  group;
      while (bytes_sent - start < n_bytes) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            offer_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         end else if (pick < 20) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
               offer_byte(8'h80 | 8'($urandom_range(0, 127)), i == len - 1);
         end else begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 12)
                                              : $urandom_range(1, 5);
            for (int i = 0; i < len; i++) begin
               group = 8'($urandom_range(0, 127));
               // Keep some long numbers within range
               if (i == 4 && $urandom_range(0, 1)) group = 8'($urandom_range(0, 15));
               if (i >= 5 && $urandom_range(0, 1)) group = 8'd0;
               if (i == len - 1)
                  offer_byte({1'b0, group[6:0]}, $urandom_range(0, 7) == 0);
               else
                  offer_byte({1'b1, group[6:0]}, 1'b0);
            end
         end
      end
      wait_for_results();
   endtask

   // Hold the receiver off while one-byte numbers keep coming
   task automatic test_rsp_hold_off();
      tx_max_gap  = 0;
      rx_hold_req = 150;
      for (int i = 0; i < 30; i++)
         offer_byte(8'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      wait_for_results();
   endtask

   // Let every result drain before each next number
   task automatic test_sender_pause();
      tx_max_gap   = 3;
      tx_max_burst = 2;
      rx_max_stall = 3;
      rx_max_run   = 3;
      for (int i = 0; i < 6; i++) begin
         offer_byte(8'h80 | 8'($urandom_range(0, 127)), 1'b0);
         offer_byte(8'($urandom_range(0, 127)), 1'b0);
         wait_for_results();
      end
   endtask

   initial begin
      clear_number();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();

      tx_max_gap   = 4;
      tx_max_burst = 8;
      rx_max_stall = 4;
      rx_max_run   = 8;
      test_random_stream(130);

      tx_max_gap   = 0;
      rx_max_stall = 0;
      test_random_stream(130);

      tx_max_gap   = 10;
      tx_max_burst = 3;
      rx_max_stall = 2;
      rx_max_run   = 2;
      test_random_stream(130);

      test_rsp_hold_off();
      test_sender_pause();

      // Drain, then keep watching for any stray result from the block
      wait_for_results();
      repeat (20) @(posedge clock);
      if (pending_results.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("[signed_varint_decoder_unit] OK");
      end else begin
         $display("[signed_varint_decoder_unit] ERROR");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #2000000;
      $display("[signed_varint_decoder_unit] ERROR");
      $finish;
   end

endmodule

### files.f
rtl/svd_pkg.sv
rtl/svd_step.sv
rtl/signed_varint_decoder_unit.sv
rtl/svd_checker.sv
tb/tb_top.sv
